// ===== rtl/core/rvdalu_pkg.sv =====
// Package for the RV64I subset decode and ALU block.
// Holds the request and result structs, opcode and function codes, and the
// control struct passed from the decoder to the ALU. No dependencies.
`default_nettype none

package rvdalu_pkg;

  localparam logic [6:0] OPC_RTYPE  = 7'h33;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_IALU   = 7'h13;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6F;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  localparam logic [2:0] F3_ADD = 3'd0;
  localparam logic [2:0] F3_SLL = 3'd1;
  localparam logic [2:0] F3_OR  = 3'd6;
  localparam logic [2:0] F3_AND = 3'd7;

  typedef enum logic [2:0] {
    ALU_AND  = 3'd0,
    ALU_OR   = 3'd1,
    ALU_ADD  = 3'd2,
    ALU_SHL  = 3'd3,
    ALU_SUB  = 3'd4,
    ALU_NONE = 3'd5
  } alu_op_t;

  typedef struct packed {
    logic    reg_write;
    logic    mem_read;
    logic    mem_write;
    logic    mem_to_reg;
    logic    branch_ctl;
    logic    alu_src_imm;
    logic    unsupported;
    alu_op_t alu_op;
  } ctrl_t;

  typedef struct packed {
    logic [31:0] instr_word;
    logic [63:0] src1_value;
    logic [63:0] src2_value;
  } in_req_t;

  typedef struct packed {
    logic [63:0] alu_out;
    logic        zero_flag;
    logic [63:0] imm_value;
    logic [4:0]  dest_reg;
    logic        reg_write;
    logic        mem_read;
    logic        mem_write;
    logic        mem_to_reg;
    logic        branch_ctl;
    logic        alu_src_imm;
    logic        unsupported;
  } out_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/rvdalu_ctrl.sv =====
// Main control decoder: opcode, funct3 and funct7 to control signals and ALU operation.
// Depends on rvdalu_pkg.
`default_nettype none

module rvdalu_ctrl
  import rvdalu_pkg::*;
(
  input  wire logic [31:0] instr_word,
  output ctrl_t            ctrl
);

  logic [6:0] opc;
  logic [2:0] f3;
  logic [6:0] f7;
  alu_op_t    rop;

  assign opc = instr_word[6:0];
  assign f3  = instr_word[14:12];
  assign f7  = instr_word[31:25];

  always_comb begin
    if (f7 == F7_BASE && f3 == F3_ADD) begin
      rop = ALU_ADD;
    end else if (f7 == F7_ALT && f3 == F3_ADD) begin
      rop = ALU_SUB;
    end else if (f7 == F7_BASE && f3 == F3_AND) begin
      rop = ALU_AND;
    end else if (f7 == F7_BASE && f3 == F3_OR) begin
      rop = ALU_OR;
    end else if (f7 == F7_BASE && f3 == F3_SLL) begin
      rop = ALU_SHL;
    end else begin
      rop = ALU_NONE;
    end
  end

  always_comb begin
    ctrl = '0;
    ctrl.alu_op = ALU_NONE;
    unique case (opc)
      OPC_RTYPE: begin
        ctrl.reg_write   = 1'b1;
        ctrl.alu_op      = rop;
        ctrl.unsupported = (rop == ALU_NONE);
      end
      OPC_LOAD: begin
        ctrl.reg_write   = 1'b1;
        ctrl.mem_read    = 1'b1;
        ctrl.mem_to_reg  = 1'b1;
        ctrl.alu_src_imm = 1'b1;
        ctrl.alu_op      = ALU_ADD;
      end
      OPC_STORE: begin
        ctrl.mem_write   = 1'b1;
        ctrl.alu_src_imm = 1'b1;
        ctrl.alu_op      = ALU_ADD;
      end
      OPC_BRANCH: begin
        ctrl.branch_ctl = 1'b1;
        ctrl.alu_op     = ALU_SUB;
      end
      OPC_IALU: begin
        ctrl.reg_write   = 1'b1;
        ctrl.alu_src_imm = 1'b1;
        ctrl.alu_op      = (f3 == F3_SLL) ? ALU_SHL : ALU_ADD;
      end
      default: begin
        ctrl.unsupported = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/rvdalu_immgen.sv =====
// Immediate generator for the I, S, B, U and J instruction formats.
// Depends on rvdalu_pkg.
`default_nettype none

module rvdalu_immgen
  import rvdalu_pkg::*;
(
  input  wire logic [31:0] instr_word,
  output logic      [63:0] imm_value
);

  logic [31:0] w;

  assign w = instr_word;

  always_comb begin
    unique case (w[6:0]) inside
      OPC_IALU, OPC_LOAD, OPC_SYSTEM: begin
        imm_value = {{52{w[31]}}, w[31:20]};
      end
      OPC_STORE: begin
        imm_value = {{52{w[31]}}, w[31:25], w[11:7]};
      end
      OPC_BRANCH: begin
        imm_value = {{52{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
      end
      OPC_LUI, OPC_AUIPC: begin
        imm_value = {32'd0, w[31:12], 12'd0};
      end
      OPC_JAL: begin
        imm_value = {{44{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
      end
      default: begin
        imm_value = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/rvdalu_alu.sv =====
// 64-bit ALU with add, sub, and, or, shift left and a zero flag.
// Depends on rvdalu_pkg for the operation codes.
`default_nettype none

module rvdalu_alu
  import rvdalu_pkg::*;
(
  input  wire logic [63:0] op_a,
  input  wire logic [63:0] op_b,
  input  wire alu_op_t     alu_op,
  output logic      [63:0] result,
  output logic             zero_flag
);

  always_comb begin
    case (alu_op)
      ALU_ADD: result = op_a + op_b;
      ALU_SUB: result = op_a - op_b;
      ALU_AND: result = op_a & op_b;
      ALU_OR:  result = op_a | op_b;
      ALU_SHL: result = op_a << op_b[4:0];
      default: result = '0;
    endcase
  end

  assign zero_flag = (result == '0);

endmodule

`default_nettype wire

// ===== rtl/core/riscv_decode_and_alu.sv =====
// Top level of the RV64I subset decode and ALU block: input register, decode,
// immediate generation and ALU, then a result register.
// Depends on rvdalu_pkg, rvdalu_ctrl, rvdalu_immgen and rvdalu_alu.
//
//   channel  | ports                          | carries
//   ---------+--------------------------------+------------------------------
//   in       | in_valid, in_stall, in_data    | instruction and two operands
//   out      | out_valid, out_stall, out_data | ALU result, immediate, controls
//
// An accepted request is loaded into the input register; its decode and ALU
// result is then loaded into the result register, which drives out_data.
// A new request is accepted every cycle while the output is not stalled.
// Reset clears both valid bits; payload registers are not reset.
// A stall on the output holds a full result register and, once the input
// register is also full, raises in_stall.
`default_nettype none

module riscv_decode_and_alu
  import rvdalu_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_req_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_rsp_t      out_data
);

  logic     req_valid_r;
  logic     req_valid_nxt;
  in_req_t  req_r;
  logic     rsp_valid_r;
  logic     rsp_valid_nxt;
  out_rsp_t rsp_r;
  out_rsp_t rsp_nxt;
  logic     rsp_load;
  logic     req_load;
  ctrl_t    ctrl;
  logic [63:0] imm;
  logic [63:0] op_b;
  logic [63:0] alu_res;
  logic        alu_zero;

  assign rsp_load = req_valid_r && (!rsp_valid_r || !out_stall);
  assign in_stall = req_valid_r && !rsp_load;
  assign req_load = in_valid && !in_stall;

  assign req_valid_nxt = req_load || (req_valid_r && !rsp_load);
  assign rsp_valid_nxt = rsp_load || (rsp_valid_r && out_stall);

  rvdalu_ctrl u_ctrl (
    .instr_word (req_r.instr_word),
    .ctrl       (ctrl)
  );

  rvdalu_immgen u_immgen (
    .instr_word (req_r.instr_word),
    .imm_value  (imm)
  );

  assign op_b = ctrl.alu_src_imm ? imm : req_r.src2_value;

  rvdalu_alu u_alu (
    .op_a      (req_r.src1_value),
    .op_b      (op_b),
    .alu_op    (ctrl.alu_op),
    .result    (alu_res),
    .zero_flag (alu_zero)
  );

  always_comb begin
    rsp_nxt.alu_out     = alu_res;
    rsp_nxt.zero_flag   = alu_zero;
    rsp_nxt.imm_value   = imm;
    rsp_nxt.dest_reg    = req_r.instr_word[11:7];
    rsp_nxt.reg_write   = ctrl.reg_write;
    rsp_nxt.mem_read    = ctrl.mem_read;
    rsp_nxt.mem_write   = ctrl.mem_write;
    rsp_nxt.mem_to_reg  = ctrl.mem_to_reg;
    rsp_nxt.branch_ctl  = ctrl.branch_ctl;
    rsp_nxt.alu_src_imm = ctrl.alu_src_imm;
    rsp_nxt.unsupported = ctrl.unsupported;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      rsp_valid_r <= 1'b0;
    end else begin
      req_valid_r <= req_valid_nxt;
      rsp_valid_r <= rsp_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req_load) begin
      req_r <= in_data;
    end
    if (rsp_load) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_valid = rsp_valid_r;
  assign out_data  = rsp_r;

endmodule

`default_nettype wire
